// ===== hw/rtl/soft_pwm_frame_output_assert.svh =====
// assertion macros used by the pwm frame output datapath
`ifndef SOFT_PWM_FRAME_OUTPUT_ASSERT_SVH
`define SOFT_PWM_FRAME_OUTPUT_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SPFO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SPFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPFO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPFO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/spfo_pkg.sv =====
// types, microcode table and constants of the pwm frame output block
`timescale 1ns / 1ps
package spfo_pkg;

	localparam int MID_PERIOD = 5;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_OUTPUTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MASK = 1'd1;

	typedef logic [3:0] step_t;

	localparam step_t STEP_CLEAR = 4'd0;
	localparam step_t STEP_IDLE = 4'd1;
	localparam step_t STEP_DISP = 4'd2;
	localparam step_t STEP_PRIME = 4'd3;
	localparam step_t STEP_RMW = 4'd4;
	localparam step_t STEP_RET = 4'd5;
	localparam step_t STEP_TRD = 4'd6;
	localparam step_t STEP_TOUT = 4'd7;
	localparam step_t STEP_TRET = 4'd8;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_IDX_NEXT,
		ADDR_SLOT
	} addr_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ZERO,
		WR_RMW
	} wr_sel_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_LAST,
		C_NOT_ACCEPT,
		C_OP_TICK,
		C_OUT_STALL
	} cond_t;

	typedef struct packed {
		logic      rd_en;
		addr_sel_t addr_sel;
		wr_sel_t   wr_sel;
		logic      idx_inc;
		logic      in_ready;
		logic      emit;
		cond_t     cond;
		step_t     target;
	} ctrl_t;

	typedef struct packed {
		logic last;
		logic accept;
		logic op_tick;
		logic out_stall;
	} status_t;

	// control store: one word per step, jump to target when cond holds
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		cw = '{rd_en: 1'b0, addr_sel: ADDR_IDX, wr_sel: WR_NONE, idx_inc: 1'b0,
			in_ready: 1'b0, emit: 1'b0, cond: C_ALWAYS, target: STEP_IDLE};
		case (step)
			STEP_CLEAR: begin
				cw.wr_sel = WR_ZERO;
				cw.idx_inc = 1'b1;
				cw.cond = C_NOT_LAST;
				cw.target = STEP_CLEAR;
			end
			STEP_IDLE: begin
				cw.in_ready = 1'b1;
				cw.cond = C_NOT_ACCEPT;
				cw.target = STEP_IDLE;
			end
			STEP_DISP: begin
				cw.cond = C_OP_TICK;
				cw.target = STEP_TRD;
			end
			STEP_PRIME: begin
				cw.rd_en = 1'b1;
				cw.addr_sel = ADDR_IDX;
				cw.cond = C_NEVER;
			end
			STEP_RMW: begin
				cw.rd_en = 1'b1;
				cw.addr_sel = ADDR_IDX_NEXT;
				cw.wr_sel = WR_RMW;
				cw.idx_inc = 1'b1;
				cw.cond = C_NOT_LAST;
				cw.target = STEP_RMW;
			end
			STEP_RET: begin
				cw.cond = C_ALWAYS;
			end
			STEP_TRD: begin
				cw.rd_en = 1'b1;
				cw.addr_sel = ADDR_SLOT;
				cw.cond = C_NEVER;
			end
			STEP_TOUT: begin
				cw.emit = 1'b1;
				cw.cond = C_OUT_STALL;
				cw.target = STEP_TOUT;
			end
			STEP_TRET: begin
				cw.cond = C_ALWAYS;
			end
			default: begin
				cw.cond = C_ALWAYS;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hw/rtl/spfo_if.sv =====
// item channels of the pwm frame output block
`timescale 1ns / 1ps
interface spfo_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] channel_mask;
	logic [7:0]  duty;

	modport source(output valid, output operation, output channel_mask, output duty,
		input ready);
	modport sink(input valid, input operation, input channel_mask, input duty,
		output ready);
endinterface

interface spfo_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] port_value;
	logic        timed_trigger;

	modport source(output valid, output port_value, output timed_trigger, input ready);
	modport sink(input valid, input port_value, input timed_trigger, output ready);
endinterface

// ===== hw/rtl/spfo_sequencer.sv =====
// step counter and control store of the pwm frame output block
`timescale 1ns / 1ps
module spfo_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  spfo_pkg::status_t status,
	output spfo_pkg::ctrl_t   ctrl
);

	spfo_pkg::step_t step_q;
	spfo_pkg::step_t step_d;
	logic take;

	assign ctrl = spfo_pkg::ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			spfo_pkg::C_NEVER:      take = 1'b0;
			spfo_pkg::C_ALWAYS:     take = 1'b1;
			spfo_pkg::C_NOT_LAST:   take = !status.last;
			spfo_pkg::C_NOT_ACCEPT: take = !status.accept;
			spfo_pkg::C_OP_TICK:    take = status.op_tick;
			spfo_pkg::C_OUT_STALL:  take = status.out_stall;
			default:                take = 1'b0;
		endcase
	end

	always_comb begin
		step_d = take ? ctrl.target : step_q + spfo_pkg::step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= spfo_pkg::STEP_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== hw/rtl/spfo_datapath.sv =====
// frame store, slot and period counters, config and result register
`timescale 1ns / 1ps
`include "soft_pwm_frame_output_assert.svh"
module spfo_datapath #(
	parameter int SLOTS = 255,
	parameter int PERIODS_PER_FRAME = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spfo_pkg::ctrl_t               ctrl,
	output spfo_pkg::status_t             status,
	spfo_req_if.sink                      req,
	spfo_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [spfo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spfo_pkg::CFG_W-1:0]    cfg_data
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = (PERIODS_PER_FRAME > 1) ? $clog2(PERIODS_PER_FRAME) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	logic [31:0] mem [SLOTS];

	logic [31:0] static_q;
	logic [31:0] servo_q;
	logic        op_q;
	logic [31:0] chans_q;
	logic [7:0]  duty_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] slot_q;
	logic [PW-1:0] period_q;
	logic [31:0] active_q;
	logic [31:0] rdata_q;
	logic        out_valid_q;
	logic [31:0] out_value_q;
	logic        out_trig_q;

	logic          accept;
	logic          idx_last;
	logic [AW-1:0] idx_next;
	logic          out_stall;
	logic          emit_fire;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [31:0]   wr_data;
	logic          slot_wrap;
	logic [PW:0]   period_inc;
	logic          frame_wrap;
	logic          trig_d;

	assign accept = req.valid && ctrl.in_ready;
	assign req.ready = ctrl.in_ready;
	assign idx_last = (idx_q == LAST_SLOT);
	assign idx_next = idx_last ? '0 : idx_q + AW'(1);
	assign out_stall = out_valid_q && !rsp.ready;
	assign emit_fire = ctrl.emit && !out_stall;

	assign status = '{last: idx_last, accept: accept, op_tick: !op_q, out_stall: out_stall};

	always_comb begin
		case (ctrl.addr_sel)
			spfo_pkg::ADDR_IDX:      rd_addr = idx_q;
			spfo_pkg::ADDR_IDX_NEXT: rd_addr = idx_next;
			spfo_pkg::ADDR_SLOT:     rd_addr = slot_q;
			default:                 rd_addr = idx_q;
		endcase
	end

	// in a duty write slots below the duty get the channels set, the rest get them cleared; the clear pass writes zeros
	always_comb begin
		mem_we = (ctrl.wr_sel != spfo_pkg::WR_NONE);
		if (ctrl.wr_sel == spfo_pkg::WR_RMW) begin
			if (32'(idx_q) < 32'(duty_q)) begin
				wr_data = rdata_q | chans_q;
			end else begin
				wr_data = rdata_q & ~chans_q;
			end
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign slot_wrap = (slot_q == LAST_SLOT);
	assign period_inc = {1'b0, period_q} + (PW + 1)'(1);
	assign frame_wrap = (period_inc >= (PW + 1)'(PERIODS_PER_FRAME));
	assign trig_d = slot_wrap && (frame_wrap || (32'(period_inc) == spfo_pkg::MID_PERIOD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_q <= '0;
			servo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spfo_pkg::CFG_STATIC_OUTPUTS: static_q <= cfg_data;
				spfo_pkg::CFG_SERVO_MASK:     servo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.operation;
			chans_q <= req.channel_mask;
			duty_q <= req.duty;
		end
		if (emit_fire) begin
			out_value_q <= (static_q | rdata_q) & ~active_q;
			out_trig_q <= trig_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			slot_q <= '0;
			period_q <= '0;
			active_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.idx_inc) begin
				idx_q <= idx_next;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				slot_q <= slot_wrap ? '0 : slot_q + AW'(1);
				if (slot_wrap) begin
					if (frame_wrap) begin
						period_q <= '0;
						active_q <= '0;
					end else begin
						period_q <= period_inc[PW-1:0];
						active_q <= servo_q;
					end
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.port_value = out_value_q;
	assign rsp.timed_trigger = out_trig_q;

	// read-modify-write never reads the entry it writes in the same cycle
	`SPFO_ASSERT_SAME(a_rmw_no_overlap, clk, arst_n, mem_we && ctrl.rd_en, rd_addr != idx_q)
	`SPFO_ASSERT_SAME(a_slot_bound, clk, arst_n, 1'b1, 32'(slot_q) < SLOTS)
	`SPFO_ASSERT_SAME(a_period_bound, clk, arst_n, 1'b1, 32'(period_q) < PERIODS_PER_FRAME)
	// a trigger goes out only with the tick that wraps the slot pointer
	`SPFO_ASSERT_NEXT(a_trig_wrap, clk, arst_n, emit_fire && trig_d, slot_q == '0)

endmodule

// ===== hw/rtl/soft_pwm_frame_output.sv =====
// top level: 32-output pwm generator with a servo frame
// tick: the slot entry is read, then the result is registered once the output is not stalled; one tick at a time
// duty write: rewrites all SLOTS entries one a cycle; no new item is accepted until that pass is through
// the rate is set by the single write port of the frame store and the microcode steps
// reset: control and config clear at once, then a pass over all SLOTS entries zeroes the frame store
// no item is accepted during that pass; configuration writes are taken throughout
`timescale 1ns / 1ps
module soft_pwm_frame_output #(
	parameter int SLOTS = 255,
	parameter int PERIODS_PER_FRAME = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	spfo_req_if.sink                      req,
	spfo_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [spfo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spfo_pkg::CFG_W-1:0]    cfg_data
);

	spfo_pkg::ctrl_t   ctrl;
	spfo_pkg::status_t status;

	spfo_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	spfo_datapath #(
		.SLOTS             (SLOTS),
		.PERIODS_PER_FRAME (PERIODS_PER_FRAME)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
